FILE: rtl/core/vacs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Viterbi ACS package
// Shared constants and the expected-symbol function of the rate one-half
// add-compare-select block.
// ----------------------------------------------------------------------------
package vacs_pkg;

  localparam int DEF_CONSTRAINT_LEN = 3;
  localparam int DEF_METRIC_BITS    = 16;

  localparam int SYM_W     = 2;
  localparam int POLY_W    = 3;
  localparam int SURV_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [POLY_W-1:0] POLY_UPPER_RESET = 3'd5;
  localparam logic [POLY_W-1:0] POLY_LOWER_RESET = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLY_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_LOWER = 2'd1;

  // Only the low three encoder register bits meet a tap, since the
  // generator registers are three bits wide.
  function automatic logic [SYM_W-1:0] expected_symbol(
    input logic [POLY_W-1:0] enc_reg,
    input logic [POLY_W-1:0] poly_upper,
    input logic [POLY_W-1:0] poly_lower
  );
    expected_symbol = {^(enc_reg & poly_upper), ^(enc_reg & poly_lower)};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/viterbi_add_compare_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Viterbi add-compare-select
// Hard-decision ACS stage for a rate one-half convolutional code. The path
// metrics live in a two-bank memory; one trellis state is updated per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one received symbol
//   and a frame-start flag per item. The output channel (out_valid_o /
//   out_stall_i) returns the survivor bits of states 0 to 3 for each item.
//   Polynomials are to be written through cfg_valid_i / cfg_ready_o while
//   idle, which the block itself does not enforce; the port is always ready
//   and indexes beyond the list are ignored. After acceptance an item
//   sweeps the states one by one through the single ACS unit fed by the
//   metric memory, then drains the read pipeline (ST_LAST) and hands the
//   result over (ST_DONE). The next item is taken in the cycle after that,
//   so a new item is accepted only once the last one is through.
//   A finished result waits in the output register while the next item is
//   accepted and processed; if the receiver is still stalling when that
//   item finishes, the block holds and accepts nothing further.
//   Reset restores the default polynomials and marks the metrics as
//   initial (state zero at 0, the others at the maximum); no memory sweep.
// ----------------------------------------------------------------------------
module viterbi_add_compare_select #(
  parameter int CONSTRAINT_LEN = vacs_pkg::DEF_CONSTRAINT_LEN,
  parameter int METRIC_BITS    = vacs_pkg::DEF_METRIC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [vacs_pkg::SYM_W-1:0]         rx_symbol_i,
  input  wire logic                               frame_start_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [vacs_pkg::SURV_W-1:0]        survivor_bits_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [vacs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [vacs_pkg::POLY_W-1:0]        cfg_data_i
);

  localparam int STATE_W = CONSTRAINT_LEN - 1;
  localparam int NUM_STATES = 1 << STATE_W;
  localparam logic [STATE_W-1:0]     TopBit    = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic [METRIC_BITS-1:0] MetricMax = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LAST,
    ST_DONE
  } acs_state_e;

  acs_state_e                    state_q;
  logic [vacs_pkg::POLY_W-1:0]   poly_upper_q;
  logic [vacs_pkg::POLY_W-1:0]   poly_lower_q;
  logic [vacs_pkg::SYM_W-1:0]    rx_q;
  logic                          init_q;
  logic                          init_now_q;
  logic                          bank_q;
  logic [STATE_W-1:0]            cnt_q;
  logic                          ex_valid_q;
  logic [STATE_W-1:0]            ex_state_q;
  logic [vacs_pkg::SURV_W-1:0]   surv_acc_q;
  logic                          out_valid_q;
  logic [vacs_pkg::SURV_W-1:0]   out_surv_q;

  logic [METRIC_BITS-1:0]        mem_q [2*NUM_STATES];
  logic [METRIC_BITS-1:0]        rd0_q;
  logic [METRIC_BITS-1:0]        rd1_q;

  logic [STATE_W-1:0]            rd_pred0;
  logic [STATE_W-1:0]            rd_pred1;
  logic [STATE_W-1:0]            ex_pred0;
  logic [METRIC_BITS-1:0]        ex_metric0;
  logic [METRIC_BITS-1:0]        ex_metric1;
  logic [METRIC_BITS-1:0]        new_metric;
  logic                          choose_upper;
  logic                          out_free;

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign survivor_bits_o = out_surv_q;
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || !out_stall_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_upper_q <= vacs_pkg::POLY_UPPER_RESET;
      poly_lower_q <= vacs_pkg::POLY_LOWER_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vacs_pkg::REG_POLY_UPPER: begin
          poly_upper_q <= cfg_data_i;
        end
        vacs_pkg::REG_POLY_LOWER: begin
          poly_lower_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Old metrics are read from one bank while the new ones go to the other,
  // so reads and writes of one item never meet on the same entry.
  assign rd_pred0 = cnt_q >> 1;
  assign rd_pred1 = rd_pred0 | TopBit;

  always_ff @(posedge clk_i) begin
    rd0_q <= mem_q[{bank_q, rd_pred0}];
    rd1_q <= mem_q[{bank_q, rd_pred1}];
    if (ex_valid_q) begin
      mem_q[{!bank_q, ex_state_q}] <= new_metric;
    end
  end

  // Right after reset or a frame start the stored bank is stale and the
  // initial metrics are substituted on the read side.
  assign ex_pred0   = ex_state_q >> 1;
  assign ex_metric0 = init_now_q ? ((ex_pred0 == '0) ? '0 : MetricMax) : rd0_q;
  assign ex_metric1 = init_now_q ? MetricMax : rd1_q;

  vacs_acs_unit #(
    .STATE_W     (STATE_W),
    .METRIC_BITS (METRIC_BITS)
  ) u_acs (
    .state_i        (ex_state_q),
    .metric0_i      (ex_metric0),
    .metric1_i      (ex_metric1),
    .rx_symbol_i    (rx_q),
    .poly_upper_i   (poly_upper_q),
    .poly_lower_i   (poly_lower_q),
    .metric_o       (new_metric),
    .choose_upper_o (choose_upper)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      init_q      <= 1'b1;
      init_now_q  <= 1'b0;
      bank_q      <= 1'b0;
      cnt_q       <= '0;
      ex_valid_q  <= 1'b0;
      ex_state_q  <= '0;
      surv_acc_q  <= '0;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
      out_surv_q  <= '0;
    end else begin
      // In the final state the output register is reloaded below instead.
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      ex_valid_q <= (state_q == ST_RUN);
      ex_state_q <= cnt_q;

      if (ex_valid_q && (32'(ex_state_q) < vacs_pkg::SURV_W)) begin
        surv_acc_q[ex_state_q[1:0]] <= choose_upper;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            rx_q       <= rx_symbol_i;
            init_now_q <= init_q || frame_start_i;
            cnt_q      <= '0;
            surv_acc_q <= '0;
            state_q    <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '1) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_surv_q  <= surv_acc_q;
            bank_q      <= !bank_q;
            init_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted item did not make the block busy");

  a_ex_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_valid_q |-> $past(state_q == ST_RUN))
    else $error("metric write outside the state sweep");

  a_result_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result offered before the sweep finished");

  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> ($past(state_q == ST_DONE) && !init_q))
    else $error("metric bank swapped mid-item");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/vacs_acs_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Viterbi ACS unit
// Adds the branch metrics to both predecessor metrics of one next state,
// saturates the sums and selects the survivor.
// ----------------------------------------------------------------------------
module vacs_acs_unit #(
  parameter int STATE_W     = 2,
  parameter int METRIC_BITS = vacs_pkg::DEF_METRIC_BITS
) (
  input  wire logic [STATE_W-1:0]            state_i,
  input  wire logic [METRIC_BITS-1:0]        metric0_i,
  input  wire logic [METRIC_BITS-1:0]        metric1_i,
  input  wire logic [vacs_pkg::SYM_W-1:0]    rx_symbol_i,
  input  wire logic [vacs_pkg::POLY_W-1:0]   poly_upper_i,
  input  wire logic [vacs_pkg::POLY_W-1:0]   poly_lower_i,
  output logic      [METRIC_BITS-1:0]        metric_o,
  output logic                               choose_upper_o
);

  localparam logic [STATE_W-1:0]     TopBit    = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic [METRIC_BITS-1:0] MetricMax = '1;

  logic [STATE_W-1:0]              pred0;
  logic [STATE_W-1:0]              pred1;
  logic [vacs_pkg::SYM_W-1:0]      diff0;
  logic [vacs_pkg::SYM_W-1:0]      diff1;
  logic [METRIC_BITS:0]            sum0;
  logic [METRIC_BITS:0]            sum1;
  logic [METRIC_BITS-1:0]          sat0;
  logic [METRIC_BITS-1:0]          sat1;

  assign pred0 = state_i >> 1;
  assign pred1 = pred0 | TopBit;

  assign diff0 = rx_symbol_i ^ vacs_pkg::expected_symbol({pred0[1:0], state_i[0]},
                                                         poly_upper_i, poly_lower_i);
  assign diff1 = rx_symbol_i ^ vacs_pkg::expected_symbol({pred1[1:0], state_i[0]},
                                                         poly_upper_i, poly_lower_i);

  assign sum0 = {1'b0, metric0_i} + (METRIC_BITS+1)'(diff0[1]) + (METRIC_BITS+1)'(diff0[0]);
  assign sum1 = {1'b0, metric1_i} + (METRIC_BITS+1)'(diff1[1]) + (METRIC_BITS+1)'(diff1[0]);

  assign sat0 = sum0[METRIC_BITS] ? MetricMax : sum0[METRIC_BITS-1:0];
  assign sat1 = sum1[METRIC_BITS] ? MetricMax : sum1[METRIC_BITS-1:0];

  // A tie goes to the predecessor without the top bit.
  assign choose_upper_o = (sat1 < sat0);
  assign metric_o       = choose_upper_o ? sat1 : sat0;

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viterbi add-compare-select testbench
// Streams received symbols, mostly whole encoded frames with sprinkled bit
// errors, through the block under bursty input and stalling output, and
// checks every survivor word against a trellis cost model kept alongside.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STATE_W     = vacs_pkg::DEF_CONSTRAINT_LEN - 1;
  localparam int NUM_STATES  = 1 << STATE_W;
  localparam int METRIC_W    = vacs_pkg::DEF_METRIC_BITS;
  localparam int ITEM_CYCLES = NUM_STATES + 3;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 2000;

  localparam int SYM_W     = vacs_pkg::SYM_W;
  localparam int POLY_W    = vacs_pkg::POLY_W;
  localparam int SURV_W    = vacs_pkg::SURV_W;
  localparam int CFG_IDX_W = vacs_pkg::CFG_IDX_W;

  localparam logic [POLY_W-1:0]    POLY_UPPER_RESET = vacs_pkg::POLY_UPPER_RESET;
  localparam logic [POLY_W-1:0]    POLY_LOWER_RESET = vacs_pkg::POLY_LOWER_RESET;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_UPPER   = vacs_pkg::REG_POLY_UPPER;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_LOWER   = vacs_pkg::REG_POLY_LOWER;

  localparam logic [STATE_W-1:0]   TOP_STATE = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic [METRIC_W-1:0]  COST_MAX  = '1;
  // Indexes past the register list; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [SYM_W-1:0] rx_symbol;
    logic             frame_start;
  } symbol_item_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic [SYM_W-1:0]     rx_symbol = '0;
  logic                 frame_start = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [POLY_W-1:0]    cfg_data = '0;
  wire                  in_stall_o;
  wire                  out_valid_o;
  wire  [SURV_W-1:0]    survivor_bits_o;
  wire                  cfg_ready_o;

  viterbi_add_compare_select #(
    .CONSTRAINT_LEN(vacs_pkg::DEF_CONSTRAINT_LEN),
    .METRIC_BITS   (vacs_pkg::DEF_METRIC_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .rx_symbol_i    (rx_symbol),
    .frame_start_i  (frame_start),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .survivor_bits_o(survivor_bits_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  symbol_item_t      symbol_queue[$];
  logic [SURV_W-1:0] survivor_fifo[$];
  int                miscompares = 0;
  int                hold_requests = 0;

  // Trellis cost model
  logic [POLY_W-1:0]   upper_taps, lower_taps;
  logic [METRIC_W-1:0] path_cost [NUM_STATES];

  function automatic logic [SYM_W-1:0] branch_label(input logic [STATE_W-1:0] pred,
                                                     input logic bit_in,
                                                     input logic [POLY_W-1:0] upper,
                                                     input logic [POLY_W-1:0] lower);
    logic [POLY_W-1:0] enc;
    enc = {pred, bit_in};
    return {^(enc & upper), ^(enc & lower)};
  endfunction

  function automatic logic [METRIC_W-1:0] branch_cost(input logic [METRIC_W-1:0] cost,
                                                       input logic [SYM_W-1:0] rx,
                                                       input logic [SYM_W-1:0] label);
    logic [SYM_W-1:0]  diff;
    logic [METRIC_W:0] total;
    diff  = rx ^ label;
    total = {1'b0, cost} + diff[1] + diff[0];
    return (total > {1'b0, COST_MAX}) ? COST_MAX : total[METRIC_W-1:0];
  endfunction

  function automatic void reset_costs();
    for (int s = 0; s < NUM_STATES; s++) path_cost[s] = (s == 0) ? '0 : COST_MAX;
  endfunction

  function automatic logic [SURV_W-1:0] acs_update(input logic [SYM_W-1:0] rx,
                                                   input logic fs);
    logic [METRIC_W-1:0] next_cost [NUM_STATES];
    logic [METRIC_W-1:0] via_low, via_high;
    logic [STATE_W-1:0]  st, low_pred, high_pred;
    logic [SURV_W-1:0]   surv;
    surv = '0;
    if (fs) reset_costs();
    for (int s = 0; s < NUM_STATES; s++) begin
      st        = STATE_W'(s);
      low_pred  = st >> 1;
      high_pred = low_pred | TOP_STATE;
      via_low   = branch_cost(path_cost[low_pred], rx,
                              branch_label(low_pred, st[0], upper_taps, lower_taps));
      via_high  = branch_cost(path_cost[high_pred], rx,
                              branch_label(high_pred, st[0], upper_taps, lower_taps));
      // A tie, saturated sums included, keeps the predecessor without the top bit.
      if (via_high < via_low) begin
        next_cost[s] = via_high;
        if (s < SURV_W) surv[s] = 1'b1;
      end else begin
        next_cost[s] = via_low;
      end
    end
    path_cost = next_cost;
    return surv;
  endfunction

  // Driver: bursts of items separated by random gaps; also tracks config writes.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      rx_symbol   <= '0;
      frame_start <= 1'b0;
      upper_taps  = POLY_UPPER_RESET;
      lower_taps  = POLY_LOWER_RESET;
      reset_costs();
    end else begin
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          REG_POLY_UPPER: upper_taps = cfg_data;
          REG_POLY_LOWER: lower_taps = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall_o) begin
        survivor_fifo.push_back(acs_update(rx_symbol, frame_start));
        void'(symbol_queue.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else if (in_valid) begin
        // Stalled: hold the item as it is.
      end
      if (in_valid && in_stall_o) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (symbol_queue.size() != 0) begin
        in_valid    <= 1'b1;
        rx_symbol   <= symbol_queue[0].rx_symbol;
        frame_start <= symbol_queue[0].frame_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus long holds on request.
  rx_mode_e rx_mode = RX_FREE;
  int       mode_left = 0;
  int       hold_left = 0;
  int       holds_done = 0;
  int       rx_tick = 0;
  logic     stall_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        rx_tick++;
        case (rx_mode)
          RX_FREE:     stall_next = 1'b0;
          RX_COIN:     stall_next = 1'($urandom);
          RX_PERIODIC: stall_next = (rx_tick % 8) < 3;
          default:     stall_next = ($urandom_range(0, 9) == 0);
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // Monitor
  logic [SURV_W-1:0] wanted;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (survivor_fifo.size() == 0) begin
        if (miscompares < 10)
          $display("unexpected survivor word %h at %0t", survivor_bits_o, $realtime);
        miscompares++;
      end else begin
        wanted = survivor_fifo.pop_front();
        if (survivor_bits_o !== wanted) begin
          if (miscompares < 10)
            $display("survivor_bits mismatch at %0t: expected %b, got %b",
                     $realtime, wanted, survivor_bits_o);
          miscompares++;
        end
      end
    end
  end

  // Watchdog: too long without any item moving on any channel.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("viterbi_add_compare_select test failed");
      $finish;
    end
  end

  // Stimulus
  task automatic push_symbol(input logic [SYM_W-1:0] rx, input logic fs);
    symbol_item_t item;
    item.rx_symbol   = rx;
    item.frame_start = fs;
    symbol_queue.push_back(item);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POLY_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic wait_drained();
    while (symbol_queue.size() != 0 || survivor_fifo.size() != 0) @(posedge clk_i);
  endtask

  // Mostly encoded frames with random content and errors, some noise in between.
  task automatic gen_traffic(input int count, input logic [POLY_W-1:0] upper,
                             input logic [POLY_W-1:0] lower);
    int                 made;
    int                 len;
    int                 err_pct;
    logic [STATE_W-1:0] enc;
    logic               u;
    logic [SYM_W-1:0]   sym;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 3) != 0) begin
        len     = ($urandom_range(0, 11) == 0) ? $urandom_range(80, 250) : $urandom_range(1, 30);
        err_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
        enc     = '0;
        for (int k = 0; k < len; k++) begin
          u   = 1'($urandom);
          sym = branch_label(enc, u, upper, lower);
          if ($urandom_range(0, 99) < err_pct) sym ^= SYM_W'($urandom_range(1, 3));
          // Now and then a frame arrives without its start marker.
          push_symbol(sym, (k == 0) && ($urandom_range(0, 9) != 0));
          enc = {enc[STATE_W-2:0], u};
        end
      end else begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
          push_symbol(SYM_W'($urandom), $urandom_range(0, 7) == 0);
      end
      made += len;
    end
  endtask

  task automatic run_phase(input logic [POLY_W-1:0] upper, input logic [POLY_W-1:0] lower,
                           input int count, input bit long_hold);
    write_reg(REG_POLY_UPPER, upper);
    write_reg(REG_SPARE_2, POLY_W'($urandom));
    write_reg(REG_POLY_LOWER, lower);
    write_reg(REG_SPARE_3, POLY_W'($urandom));
    cfg_valid <= 1'b0;
    gen_traffic(count, upper, lower);
    if (long_hold) hold_requests++;
    wait_drained();
  endtask

  logic [STATE_W-1:0] dir_enc;
  logic [SYM_W-1:0]   dir_sym;
  logic [7:0]         dir_bits;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: metrics straight out of reset, every symbol with a frame start and all but 01
    // without one, back-to-back frame starts, then a clean and a corrupted frame.
    push_symbol(2'b11, 1'b0);
    push_symbol(2'b00, 1'b0);
    push_symbol(2'b01, 1'b1);
    push_symbol(2'b10, 1'b0);
    push_symbol(2'b11, 1'b1);
    push_symbol(2'b00, 1'b1);
    push_symbol(2'b00, 1'b1);
    push_symbol(2'b10, 1'b1);
    dir_bits = 8'b0100_1101;
    dir_enc  = '0;
    for (int k = 0; k < 8; k++) begin
      dir_sym = branch_label(dir_enc, dir_bits[k], POLY_UPPER_RESET, POLY_LOWER_RESET);
      push_symbol(dir_sym, k == 0);
      dir_enc = {dir_enc[STATE_W-2:0], dir_bits[k]};
    end
    dir_enc = '0;
    for (int k = 0; k < 8; k++) begin
      dir_sym = branch_label(dir_enc, dir_bits[k], POLY_UPPER_RESET, POLY_LOWER_RESET);
      if (k == 3) dir_sym ^= 2'b10;
      push_symbol(dir_sym, k == 0);
      dir_enc = {dir_enc[STATE_W-2:0], dir_bits[k]};
    end
    gen_traffic(150, POLY_UPPER_RESET, POLY_LOWER_RESET);
    wait_drained();

    run_phase(3'd7, 3'd5, 250, 1'b1);
    run_phase(3'd0, 3'd0, 200, 1'b0);
    run_phase(3'd7, 3'd7, 250, 1'b0);
    run_phase(POLY_W'($urandom), POLY_W'($urandom), 300, 1'b1);
    run_phase(POLY_UPPER_RESET, POLY_LOWER_RESET, 300, 1'b0);

    repeat (ITEM_CYCLES + 8) @(posedge clk_i);
    if (miscompares == 0 && survivor_fifo.size() == 0)
      $display("viterbi_add_compare_select test passed");
    else
      $display("viterbi_add_compare_select test failed");
    $finish;
  end

endmodule
